// File: src/assert_macros.svh
// Shared assertion helpers; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SC_ASSERT_IMP(lbl, ante, cons, msg) \
    `SC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: src/sconv_pkg.sv
package sconv_pkg;

    localparam logic [2:0] REG_LINE_WIDTH = 3'd0;
    localparam logic [2:0] REG_H_TAPS     = 3'd1;
    localparam logic [2:0] REG_V_TAPS     = 3'd2;
    localparam logic [2:0] REG_H_COEFS_LO = 3'd3;
    localparam logic [2:0] REG_H_COEFS_HI = 3'd4;
    localparam logic [2:0] REG_V_COEFS_LO = 3'd5;
    localparam logic [2:0] REG_V_COEFS_HI = 3'd6;
    localparam logic [2:0] REG_SAMPLE_MAX = 3'd7;

    localparam logic [1:0] SEL_PIX = 2'd0;
    localparam logic [1:0] SEL_MEM = 2'd1;
    localparam logic [1:0] SEL_HS  = 2'd2;

    localparam int FRAC_BITS = 28;
    localparam int BANDS     = 3;

    typedef struct packed {
        logic       clr;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_h_en;
        logic       acc_v_en;
    } lane_ctl_t;

    function automatic logic signed [15:0] coef_at(input logic [63:0] lo,
                                                   input logic [63:0] hi,
                                                   input logic [2:0] k);
        logic [63:0] word;
        word = k[2] ? hi : lo;
        return signed'(word[16*k[1:0] +: 16]);
    endfunction

endpackage

// File: src/sconv_lane.sv
module sconv_lane
    import sconv_pkg::*;
#(
    parameter int SB = 16,
    parameter int HW = 36,
    parameter int VW = 55
)
(
    input  logic                 clk,
    input  lane_ctl_t            ctl,
    input  logic [SB-1:0]        pix,
    input  logic signed [HW-1:0] mem,
    input  logic signed [15:0]   coef,
    output logic signed [HW-1:0] hs,
    output logic signed [VW-1:0] acc
);

    logic signed [HW-1:0]    opa;
    logic signed [HW+15:0]   prod_next;
    logic signed [HW+15:0]   prod_reg;
    logic signed [HW-1:0]    hs_reg;
    logic signed [VW-1:0]    acc_reg;

    always_comb
    begin
        case (ctl.mul_sel)
            SEL_PIX: opa = signed'({{(HW-SB){1'b0}}, pix});
            SEL_MEM: opa = mem;
            default: opa = hs_reg;
        endcase
        prod_next = opa * coef;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.clr)
        begin
            hs_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (ctl.acc_h_en)
            begin
                hs_reg <= hs_reg + prod_reg[HW-1:0];
            end
            if (ctl.acc_v_en)
            begin
                acc_reg <= acc_reg + {{(VW-HW-16){prod_reg[HW+15]}}, prod_reg};
            end
        end
    end

    assign hs  = hs_reg;
    assign acc = acc_reg;

endmodule

// File: src/sconv_merge.sv
`include "assert_macros.svh"

module sconv_merge
    import sconv_pkg::*;
#(
    parameter int SB = 16,
    parameter int VW = 55
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic signed [VW-1:0] acc_red,
    input  logic signed [VW-1:0] acc_green,
    input  logic signed [VW-1:0] acc_blue,
    input  logic                 last,
    input  logic [SB-1:0]        top,
    output logic                 can_load,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,  // out_red, out_green, out_blue
    output logic                 m_axis_tlast   // row_last
);

    localparam int QW = VW - FRAC_BITS + 1;

    logic signed [VW-1:0] accs [BANDS];
    logic [SB-1:0]        res  [BANDS];
    logic                 tvalid_reg;
    logic [47:0]          tdata_reg;
    logic                 tlast_reg;

    assign accs[0] = acc_red;
    assign accs[1] = acc_green;
    assign accs[2] = acc_blue;

    always_comb
    begin
        logic signed [VW:0] r;
        logic [QW-1:0]      q;
        for (int b = 0; b < BANDS; b++)
        begin
            r = {accs[b][VW-1], accs[b]} + (VW+1)'(1 << (FRAC_BITS - 1));
            q = r[VW:FRAC_BITS];
            if (r[VW])
            begin
                res[b] = '0;
            end
            else if (q > QW'(top))
            begin
                res[b] = top;
            end
            else
            begin
                res[b] = q[SB-1:0];
            end
        end
    end

    assign can_load = !tvalid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= {16'(res[2]), 16'(res[1]), 16'(res[0])};
            tlast_reg <= last;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

    `SC_ASSERT_IMP(a_no_overrun, load, can_load, "output register overwritten")

endmodule

// File: src/separable_conv_rgb_interleaved.sv
// Separable 2-D convolution of an interleaved RGB pixel stream.
// s_axis: one source pixel per transaction in raster order, red in tdata[15:0],
//   green in [31:16], blue in [47:32]; tuser marks the first pixel of a frame.
// m_axis: one filtered pixel per transaction, same packing; tlast ends a row.
// cfg: register writes (index, data), always ready; write only while idle.
// A pixel outside the valid columns only shifts into the window. A pixel
// in the valid columns walks the horizontal taps; while its row only
// fills the store it then finishes, and when it gives a pixel it goes on
// to weigh each stored row and then its own row: each band lane owns one
// multiplier that walks the taps, and the filtered-row memory has one
// port, read once per stored row. The result then goes to m_axis.
// Reset clears counters, the pixel window and the output valid and loads
// the register defaults; the filtered-row memory is not cleared and is never
// read before it is written in a frame.
// When m_axis stalls, one finished pixel waits in the output register and
// the next pixel is still taken and filtered; it then holds until the
// output register frees up.
module separable_conv_rgb_interleaved
    import sconv_pkg::*;
#(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_TAPS    = 8,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pix_red, pix_green, pix_blue
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_red, out_green, out_blue
    output logic        m_axis_tlast,   // row_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

`include "assert_macros.svh"

    localparam int SB    = SAMPLE_BITS;
    localparam int HW    = SB + 20;
    localparam int VW    = HW + 19;
    localparam int RING  = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
    localparam int SW    = (RING > 1) ? $clog2(RING) : 1;
    localparam int KW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int CW    = $clog2(MAX_WIDTH + MAX_TAPS);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = SW + TW;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_HMUL = 4'd1;
    localparam logic [3:0] ST_HACC = 4'd2;
    localparam logic [3:0] ST_VRD  = 4'd3;
    localparam logic [3:0] ST_VMUL = 4'd4;
    localparam logic [3:0] ST_VACC = 4'd5;
    localparam logic [3:0] ST_LMUL = 4'd6;
    localparam logic [3:0] ST_LACC = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [11:0] line_width_reg;
    logic [3:0]  h_taps_reg;
    logic [3:0]  v_taps_reg;
    logic [63:0] h_coefs_lo_reg;
    logic [63:0] h_coefs_hi_reg;
    logic [63:0] v_coefs_lo_reg;
    logic [63:0] v_coefs_hi_reg;
    logic [15:0] sample_max_reg;

    logic [CW-1:0] lw_eff;
    logic [TW-1:0] ht_eff;
    logic [TW-1:0] vt_eff;
    logic [CW-1:0] srcw;
    logic [SB-1:0] top;

    logic [SB-1:0] win_reg [MAX_TAPS][BANDS];

    logic [CW-1:0] column_count_reg, column_count_next;
    logic [3:0]    row_count_reg, row_count_next;
    logic [SW-1:0] oldest_slot_reg, oldest_slot_next;

    logic [3:0]      state_reg, state_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [COLW-1:0] col_reg;
    logic [SW-1:0]   base_reg;
    logic [SW-1:0]   wslot_reg;
    logic            produce_reg;
    logic            last_reg;

    logic [CW-1:0] cc, cc_inc, hoff;
    logic [3:0]    rc;
    logic [SW-1:0] os;
    logic          in_range, produce;
    logic [3:0]    fill;
    logic [SUMW-1:0] wsum, rsum;
    logic [SW-1:0] wslot, rslot;
    logic          accept;

    logic [3*HW-1:0] mem [DEPTH];
    logic [3*HW-1:0] rd_reg;
    logic            mem_re, mem_we;
    logic [AW-1:0]   rd_addr, wr_addr;

    lane_ctl_t          ctl;
    logic signed [15:0] coef;
    logic [TW-1:0]      widx;
    logic [2:0]         cidx;
    logic signed [HW-1:0] hs  [BANDS];
    logic signed [VW-1:0] acc [BANDS];
    logic               out_can_load;
    logic               out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= 12'd1024;
            h_taps_reg     <= 4'd1;
            v_taps_reg     <= 4'd1;
            h_coefs_lo_reg <= 64'd16384;
            h_coefs_hi_reg <= 64'd0;
            v_coefs_lo_reg <= 64'd16384;
            v_coefs_hi_reg <= 64'd0;
            sample_max_reg <= 16'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_WIDTH: line_width_reg <= cfg_data[11:0];
                REG_H_TAPS:     h_taps_reg     <= cfg_data[3:0];
                REG_V_TAPS:     v_taps_reg     <= cfg_data[3:0];
                REG_H_COEFS_LO: h_coefs_lo_reg <= cfg_data;
                REG_H_COEFS_HI: h_coefs_hi_reg <= cfg_data;
                REG_V_COEFS_LO: v_coefs_lo_reg <= cfg_data;
                REG_V_COEFS_HI: v_coefs_hi_reg <= cfg_data;
                REG_SAMPLE_MAX: sample_max_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (line_width_reg == 12'd0)
            lw_eff = CW'(1);
        else if (int'(line_width_reg) > MAX_WIDTH)
            lw_eff = CW'(MAX_WIDTH);
        else
            lw_eff = CW'(line_width_reg);

        if (h_taps_reg == 4'd0)
            ht_eff = TW'(1);
        else if (int'(h_taps_reg) > MAX_TAPS)
            ht_eff = TW'(MAX_TAPS);
        else
            ht_eff = TW'(h_taps_reg);

        if (v_taps_reg == 4'd0)
            vt_eff = TW'(1);
        else if (int'(v_taps_reg) > MAX_TAPS)
            vt_eff = TW'(MAX_TAPS);
        else
            vt_eff = TW'(v_taps_reg);

        if (int'(sample_max_reg) > (1 << SB) - 1)
            top = {SB{1'b1}};
        else
            top = SB'(sample_max_reg);

        srcw = lw_eff + CW'(ht_eff) - CW'(1);
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cc       = s_axis_tuser ? '0 : column_count_reg;
        rc       = s_axis_tuser ? '0 : row_count_reg;
        os       = s_axis_tuser ? '0 : oldest_slot_reg;
        hoff     = CW'(ht_eff) - CW'(1);
        in_range = (cc >= hoff) && ((cc - hoff) < lw_eff);
        produce  = ({1'b0, rc} >= 5'(vt_eff - TW'(1)));
        fill     = produce ? 4'(vt_eff - TW'(1)) : rc;
        wsum     = SUMW'(os) + SUMW'(fill);
        wslot    = (int'(wsum) >= RING) ? SW'(wsum - SUMW'(RING)) : SW'(wsum);

        cc_inc            = cc + CW'(1);
        column_count_next = cc_inc;
        row_count_next    = rc;
        oldest_slot_next  = os;
        if (cc_inc >= srcw)
        begin
            column_count_next = '0;
            if (produce)
                oldest_slot_next = (int'(os) + 1 >= RING) ? '0 : os + SW'(1);
            if (rc != 4'd15)
                row_count_next = rc + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            oldest_slot_reg  <= '0;
            for (int d = 0; d < MAX_TAPS; d++)
                for (int b = 0; b < BANDS; b++)
                    win_reg[d][b] <= '0;
        end
        else if (accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            oldest_slot_reg  <= oldest_slot_next;
            for (int d = MAX_TAPS - 1; d > 0; d--)
                for (int b = 0; b < BANDS; b++)
                    win_reg[d][b] <= win_reg[d-1][b];
            for (int b = 0; b < BANDS; b++)
                win_reg[0][b] <= s_axis_tdata[16*b +: SB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg     <= COLW'(cc - hoff);
            base_reg    <= os;
            wslot_reg   <= wslot;
            produce_reg <= produce;
            last_reg    <= ((cc - hoff) == lw_eff - CW'(1));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ctl        = '0;
        ctl.mul_sel = SEL_PIX;
        cidx       = 3'(k_reg);
        coef       = coef_at(h_coefs_lo_reg, h_coefs_hi_reg, cidx);
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    ctl.clr    = 1'b1;
                    k_next     = '0;
                    state_next = ST_HMUL;
                end
            end
            ST_HMUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_PIX;
                state_next  = ST_HACC;
            end
            ST_HACC:
            begin
                ctl.acc_h_en = 1'b1;
                if (TW'(k_reg) == ht_eff - TW'(1))
                begin
                    k_next = '0;
                    if (!produce_reg)
                        state_next = ST_DONE;
                    else if (vt_eff > TW'(1))
                        state_next = ST_VRD;
                    else
                        state_next = ST_LMUL;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = ST_HMUL;
                end
            end
            ST_VRD:
            begin
                mem_re     = 1'b1;
                state_next = ST_VMUL;
            end
            ST_VMUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_MEM;
                coef        = coef_at(v_coefs_lo_reg, v_coefs_hi_reg, cidx);
                state_next  = ST_VACC;
            end
            ST_VACC:
            begin
                ctl.acc_v_en = 1'b1;
                if (TW'(k_reg) + TW'(2) == vt_eff)
                    state_next = ST_LMUL;
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = ST_VRD;
                end
            end
            ST_LMUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = SEL_HS;
                cidx        = 3'(vt_eff - TW'(1));
                coef        = coef_at(v_coefs_lo_reg, v_coefs_hi_reg, cidx);
                state_next  = ST_LACC;
            end
            ST_LACC:
            begin
                ctl.acc_v_en = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!produce_reg || out_can_load)
                begin
                    mem_we     = 1'b1;
                    out_load   = produce_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign rsum    = SUMW'(base_reg) + SUMW'(k_reg);
    assign rslot   = (int'(rsum) >= RING) ? SW'(rsum - SUMW'(RING)) : SW'(rsum);
    assign rd_addr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(col_reg);
    assign wr_addr = AW'(wslot_reg) * AW'(MAX_WIDTH) + AW'(col_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= {hs[2], hs[1], hs[0]};
        if (mem_re)
            rd_reg <= mem[rd_addr];
    end

    assign widx = ht_eff - TW'(1) - TW'(k_reg);

    for (genvar b = 0; b < BANDS; b++)
    begin : g_lane
        sconv_lane #(
            .SB (SB),
            .HW (HW),
            .VW (VW)
        ) u_lane (
            .clk  (clk),
            .ctl  (ctl),
            .pix  (win_reg[widx[KW-1:0]][b]),
            .mem  (signed'(rd_reg[b*HW +: HW])),
            .coef (coef),
            .hs   (hs[b]),
            .acc  (acc[b])
        );
    end

    sconv_merge #(
        .SB (SB),
        .VW (VW)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .acc_red       (acc[0]),
        .acc_green     (acc[1]),
        .acc_blue      (acc[2]),
        .last          (last_reg),
        .top           (top),
        .can_load      (out_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `SC_ASSERT_IMP(a_slot_range, 1'b1, int'(oldest_slot_reg) < RING, "ring slot out of range")
    `SC_ASSERT_IMP(a_vread_tap, state_reg == ST_VRD, int'(k_reg) + 1 < int'(vt_eff),
        "row read past stored rows")
    `SC_ASSERT(a_load_out, (state_reg == ST_DONE && produce_reg && out_can_load) |=> m_axis_tvalid,
        "finished pixel not presented")

endmodule
